// ===== hdl/htd_pkg.sv =====
// Shared types and constants for the Huffman table decoder.
// Used by the controller, datapath, top level, result checker and testbench.
// No dependencies.
package htd_pkg;

	// Default sizing, handed down to the top-level parameters
	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int MAX_CODE_LEN_DEF  = 32;

	// Field widths
	localparam int INDEX_W = 8;
	localparam int SYM_W   = 8;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 32;

	// Bit position inside a code and inside the current byte
	localparam int POS_W     = 6;
	localparam int BIT_CNT_W = 3;

	// Entry cells are summarized in groups before the final priority select
	localparam int GROUP_SIZE  = 16;
	localparam int GROUP_LOW_W = 4;

	// Input item kinds
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DATA = 1'b1
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_RESOLVE,
		ST_FLUSH
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic load_en;
		logic start_byte;
		logic compare;
		logic commit;
		logic flush;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic in_valid;
		op_t  in_op;
		logic stop;
		logic hit;
		logic err;
		logic hit_reach;
		logic held_valid;
		logic out_free;
		logic bit_last;
	} sts_t;

endpackage

// ===== hdl/htd_if.sv =====
// Channel interfaces of the Huffman table decoder: input items,
// result items and the symbol-count write channel.
// No dependencies.

interface htd_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  entry_index;
	logic [7:0]  entry_symbol;
	logic [31:0] entry_code;
	logic [5:0]  entry_length;
	logic [7:0]  data_byte;

	modport source (
		output valid, op, entry_index, entry_symbol, entry_code, entry_length,
			data_byte,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_symbol, entry_code, entry_length,
			data_byte,
		output ready
	);
endinterface

interface htd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       decode_error;
	logic       last;
	logic       done_res;

	modport source (output valid, symbol, decode_error, last, done_res, input ready);
	modport sink (input valid, symbol, decode_error, last, done_res, output ready);
endinterface

interface htd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] symbol_count;

	modport source (output valid, symbol_count, input ready);
	modport sink (input valid, symbol_count, output ready);
endinterface

// ===== hdl/htd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/htd_ctrl.sv =====
// Controller of the Huffman table decoder: sequences load, compare,
// resolve and flush steps. Depends on htd_pkg.
module htd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  htd_pkg::sts_t sts,
	output htd_pkg::cmd_t cmd
);

	htd_pkg::state_t state_q;
	htd_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			htd_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) begin
					if (sts.in_op == htd_pkg::OP_LOAD) begin
						cmd.load_en = 1'b1;
					end else if (!sts.stop) begin
						cmd.start_byte = 1'b1;
						state_d        = htd_pkg::ST_COMPARE;
					end
				end
			end
			htd_pkg::ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = htd_pkg::ST_RESOLVE;
			end
			htd_pkg::ST_RESOLVE: begin
				// a new result first pushes the held one out; wait for room
				if (!((sts.hit || sts.err) && sts.held_valid && !sts.out_free)) begin
					cmd.commit = 1'b1;
					if (sts.hit && sts.hit_reach) begin
						state_d = htd_pkg::ST_FLUSH;
					end else if (sts.bit_last) begin
						state_d = (sts.held_valid || sts.hit || sts.err) ?
							htd_pkg::ST_FLUSH : htd_pkg::ST_IDLE;
					end else begin
						state_d = htd_pkg::ST_COMPARE;
					end
				end
			end
			htd_pkg::ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = htd_pkg::ST_IDLE;
				end
			end
			default: state_d = htd_pkg::ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	// at most one datapath action per cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_en, cmd.start_byte, cmd.compare, cmd.commit, cmd.flush}))
		else $error("conflicting datapath commands");
`endif

endmodule

// ===== hdl/htd_datapath.sv =====
// Datapath of the Huffman table decoder: entry cells, group summaries,
// symbol RAM, counters, held result and output register.
// Depends on htd_pkg, htd_if and htd_ram.
module htd_datapath #(
	parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_LEN  = htd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	htd_in_if.sink        din,
	htd_out_if.source     dout,
	htd_cfg_if.sink       cfg,
	input  htd_pkg::cmd_t cmd,
	output htd_pkg::sts_t sts
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int GS = htd_pkg::GROUP_SIZE;
	localparam int NG = (TABLE_ENTRIES + GS - 1) / GS;
	localparam int NP = NG * GS;
	localparam logic [htd_pkg::LEN_W:0] MAX_LEN = (htd_pkg::LEN_W + 1)'(MAX_CODE_LEN);

	// Entry cells
	logic [htd_pkg::CODE_W-1:0] code_q [TABLE_ENTRIES];
	logic [htd_pkg::LEN_W-1:0]  len_q  [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]   valid_q;
	logic [TABLE_ENTRIES-1:0]   alive_q;

	// Group summaries
	logic [NG-1:0]                   grp_hit_q;
	logic [NG-1:0]                   grp_alive_q;
	logic [htd_pkg::GROUP_LOW_W-1:0] grp_low_q [NG];
	logic [NG-1:0]                   grp_hit_n;
	logic [NG-1:0]                   grp_alive_n;
	logic [htd_pkg::GROUP_LOW_W-1:0] grp_low_n [NG];
	logic [NP-1:0]                   alive_n;
	logic [NP-1:0]                   end_n;

	// Bit walk state
	logic [htd_pkg::POS_W-1:0]     pos_q;
	logic [htd_pkg::BYTE_W-1:0]    byte_q;
	logic [htd_pkg::BIT_CNT_W-1:0] bit_cnt_q;
	logic                          cur_bit;

	// Counters
	logic [htd_pkg::COUNT_W-1:0] count_q;
	logic [htd_pkg::COUNT_W-1:0] decoded_q;
	logic                        stop;
	logic                        hit_reach;

	// Resolve
	logic          hit;
	logic          err;
	logic          res;
	logic [IW-1:0] win_idx;

	// Held result and output register
	logic                     held_valid_q;
	logic                     held_err_q;
	logic                     held_done_q;
	logic                     out_valid_q;
	logic [htd_pkg::SYM_W-1:0] out_sym_q;
	logic                     out_err_q;
	logic                     out_last_q;
	logic                     out_done_q;
	logic                     out_free;
	logic                     push;

	// Load handling
	logic                     idx_ok;
	logic                     load_wr;
	logic [IW-1:0]            load_idx;
	logic [htd_pkg::SYM_W-1:0] ram_rdata;

	function automatic logic code_bit(input logic [htd_pkg::CODE_W-1:0] code,
		input logic [htd_pkg::POS_W-1:0] pos);
		// positions past the stored word read as zero
		return pos[htd_pkg::POS_W-1] ? 1'b0 : code[pos[htd_pkg::POS_W-2:0]];
	endfunction

	assign idx_ok   = ({1'b0, din.entry_index} < (htd_pkg::INDEX_W + 1)'(TABLE_ENTRIES));
	assign load_wr  = cmd.load_en && idx_ok;
	assign load_idx = din.entry_index[IW-1:0];
	assign cur_bit  = byte_q[bit_cnt_q];

	// Symbol store
	htd_ram #(
		.WIDTH (htd_pkg::SYM_W),
		.DEPTH (TABLE_ENTRIES)
	) u_sym_ram (
		.clk   (clk),
		.we    (load_wr),
		.waddr (load_idx),
		.wdata (din.entry_symbol),
		.re    (cmd.commit && hit),
		.raddr (win_idx),
		.rdata (ram_rdata)
	);

	// Per-cell compare of the current stream bit
	always_comb begin
		alive_n = '0;
		end_n   = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			alive_n[i] = valid_q[i] && alive_q[i] && (len_q[i] != '0) &&
				({1'b0, len_q[i]} <= MAX_LEN) && (len_q[i] > pos_q) &&
				(code_bit(code_q[i], pos_q) == cur_bit);
			end_n[i] = alive_n[i] && (len_q[i] == pos_q + 6'd1);
		end
	end

	// Group summaries: any survivor, any end, lowest ending cell
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_hit_n[g]   = 1'b0;
			grp_alive_n[g] = 1'b0;
			grp_low_n[g]   = '0;
			for (int j = GS - 1; j >= 0; j--) begin
				grp_alive_n[g] = grp_alive_n[g] | alive_n[g*GS + j];
				if (end_n[g*GS + j]) begin
					grp_hit_n[g] = 1'b1;
					grp_low_n[g] = htd_pkg::GROUP_LOW_W'(j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			grp_hit_q   <= grp_hit_n;
			grp_alive_q <= grp_alive_n;
			grp_low_q   <= grp_low_n;
		end
	end

	// Lowest-index group with an ending code wins
	always_comb begin
		win_idx = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				win_idx = IW'(g * GS) + IW'(grp_low_q[g]);
			end
		end
	end

	assign hit       = |grp_hit_q;
	assign err       = !hit && !(|grp_alive_q);
	assign res       = hit || err;
	assign stop      = (decoded_q >= count_q);
	assign hit_reach = ({1'b0, decoded_q} + 33'd1) >= {1'b0, count_q};

	// Code and length cells
	always_ff @(posedge clk) begin
		if (load_wr) begin
			code_q[load_idx] <= din.entry_code;
			len_q[load_idx]  <= din.entry_length;
		end
	end

	// Valid and candidate bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			alive_q <= '1;
		end else begin
			if (load_wr) begin
				valid_q[load_idx] <= 1'b1;
			end
			priority if (cmd.commit && res) begin
				alive_q <= '1;
			end else if (cmd.compare) begin
				alive_q <= alive_n[TABLE_ENTRIES-1:0];
			end else if (load_wr) begin
				alive_q[load_idx] <= (pos_q == '0);
			end
		end
	end

	// Code position, bit counter and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			bit_cnt_q <= '0;
			decoded_q <= '0;
			count_q   <= '0;
		end else begin
			if (cfg.valid) begin
				count_q <= cfg.symbol_count;
			end
			if (cmd.start_byte) begin
				bit_cnt_q <= '0;
			end else if (cmd.commit) begin
				bit_cnt_q <= bit_cnt_q + 3'd1;
			end
			if (cmd.commit) begin
				pos_q <= res ? '0 : pos_q + 6'd1;
				if (hit) begin
					decoded_q <= decoded_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_byte) begin
			byte_q <= din.data_byte;
		end
	end

	// Held result: waits until it is known whether it is the byte's last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
		end else if (cmd.commit && res) begin
			held_valid_q <= 1'b1;
		end else if (cmd.flush) begin
			held_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && res) begin
			held_err_q  <= err;
			held_done_q <= hit ? hit_reach : stop;
		end
	end

	// Output register
	assign out_free = !out_valid_q || dout.ready;
	assign push     = (cmd.commit && res && held_valid_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_sym_q  <= held_err_q ? '0 : ram_rdata;
			out_err_q  <= held_err_q;
			out_done_q <= held_done_q;
			out_last_q <= cmd.flush;
		end
	end

	// Ports
	assign din.ready         = cmd.in_ready;
	assign cfg.ready         = 1'b1;
	assign dout.valid        = out_valid_q;
	assign dout.symbol       = out_sym_q;
	assign dout.decode_error = out_err_q;
	assign dout.last         = out_last_q;
	assign dout.done_res     = out_done_q;

	// Status
	assign sts.in_valid   = din.valid;
	assign sts.in_op      = htd_pkg::op_t'(din.op);
	assign sts.stop       = stop;
	assign sts.hit        = hit;
	assign sts.err        = err;
	assign sts.hit_reach  = hit_reach;
	assign sts.held_valid = held_valid_q;
	assign sts.out_free   = out_free;
	assign sts.bit_last   = (bit_cnt_q == 3'(htd_pkg::BYTE_W - 1));

`ifndef NO_ASSERTIONS
	// a result moves to the output register only when it has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result pushed over a pending transfer");

	// the byte's closing transfer always has a held result behind it
	a_flush_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> held_valid_q)
		else $error("flush without a held result");
`endif

endmodule

// ===== hdl/huffman_table_decoder_unit.sv =====
// Top level of the Huffman table decoder: controller plus datapath.
// Depends on htd_pkg, htd_if, htd_ctrl and htd_datapath.
//
// Usage:
//   din  - input items. op OP_LOAD writes one table entry (symbol, code,
//          length) at entry_index; op OP_DATA feeds one byte, LSB first.
//   dout - result items: symbol, decode_error, last (final result of the
//          byte) and done_res (symbol count reached).
//   cfg  - writes symbol_count; always ready, take it only while idle.
// Timing:
//   A load or an ignored data byte is taken in the idle state. A decoded
//   byte is accepted, then each bit passes a compare state (cell compare)
//   and a resolve state (a two-level priority select over the entry
//   groups); a flush state then hands over the byte's last result. A byte
//   that gives no result skips the flush state, and the symbol count can
//   stop the byte early. A result enters the output register when the next
//   result of the byte is found, the byte's last one in the flush state
//   after the byte ends.
// Reset:
//   Clears the table valid bits, code position, symbol counter and count.
// Stall:
//   A result needing the output register while it is still full holds the
//   bit walk; din stays not ready until the byte is finished.
module huffman_table_decoder_unit #(
	parameter int TABLE_ENTRIES = htd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_LEN  = htd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	htd_in_if.sink     din,
	htd_out_if.source  dout,
	htd_cfg_if.sink    cfg
);

	htd_pkg::cmd_t cmd;
	htd_pkg::sts_t sts;

	// Sequencer
	htd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Table cells, select and result path
	htd_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_LEN  (MAX_CODE_LEN)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ===== verif/htd_result_checker.sv =====
// Result checker for the Huffman table decoder: watches the input, result and
// symbol-count channels, predicts every result and compares it field by field.
// Depends on htd_pkg and the channel interfaces in htd_if.
module htd_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	htd_in_if           din,
	htd_out_if          dout,
	htd_cfg_if          cfg,
	output int          fail_count,
	output int          pending,
	output int          checked,
	output logic [31:0] decoded_total
);
	import htd_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	localparam int MAX_LEN = MAX_CODE_LEN_DEF;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             decode_error;
		logic             last;
		logic             done_res;
	} decode_result_t;

	// Predicted decoder state
	logic [CODE_W-1:0]  code_mem [ENTRIES];
	logic [LEN_W-1:0]   len_mem  [ENTRIES];
	logic [SYM_W-1:0]   sym_mem  [ENTRIES];
	bit                 entry_on [ENTRIES];
	bit                 alive    [ENTRIES];
	int unsigned        code_pos;
	logic [COUNT_W-1:0] decoded;
	logic [COUNT_W-1:0] target_count;

	decode_result_t expected_symbols[$];
	int n_fail;
	int n_checked;
	int n_reports;

	// every valid entry becomes a candidate again
	task automatic rearm_candidates();
		for (int i = 0; i < ENTRIES; i++) begin
			alive[i] = 1'b1;
		end
		code_pos = 0;
	endtask

	task automatic store_entry(input logic [INDEX_W-1:0] idx, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		if (idx < ENTRIES) begin
			sym_mem[idx]  = sym;
			code_mem[idx] = code;
			len_mem[idx]  = len;
			entry_on[idx] = 1'b1;
			// joins the running code only if no code bit has been seen yet
			alive[idx]    = (code_pos == 0);
		end
	endtask

	// Walk one byte LSB first and queue the results it produces
	task automatic decode_byte(input logic [BYTE_W-1:0] data);
		int hit;
		int survivors;
		int first;
		logic code_bit;
		decode_result_t r;
		first = expected_symbols.size();
		if (decoded >= target_count) begin
			return;
		end
		for (int b = 0; b < BYTE_W; b++) begin
			hit = -1;
			survivors = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!entry_on[i] || !alive[i]) begin
					continue;
				end
				if (len_mem[i] == 0 || len_mem[i] > MAX_LEN || len_mem[i] <= code_pos) begin
					alive[i] = 1'b0;
					continue;
				end
				code_bit = (code_pos < CODE_W) ? code_mem[i][code_pos] : 1'b0;
				if (code_bit != data[b]) begin
					alive[i] = 1'b0;
					continue;
				end
				if (len_mem[i] == code_pos + 1) begin
					hit = i;
					break;
				end
				survivors++;
			end
			if (hit >= 0) begin
				decoded++;
				r = '{symbol: sym_mem[hit], decode_error: 1'b0, last: 1'b0,
					done_res: (decoded >= target_count)};
				expected_symbols.insert(expected_symbols.size(), r);
				rearm_candidates();
				if (decoded >= target_count) begin
					break;
				end
			end else if (survivors == 0) begin
				// no candidate left: error result, restart on the next bit
				r = '{symbol: '0, decode_error: 1'b1, last: 1'b0,
					done_res: (decoded >= target_count)};
				expected_symbols.insert(expected_symbols.size(), r);
				rearm_candidates();
			end else begin
				code_pos = (code_pos + 1) & 6'h3F;
			end
		end
		// mark the final result of this byte
		if (expected_symbols.size() > first) begin
			expected_symbols[expected_symbols.size() - 1].last = 1'b1;
		end
	endtask

	task automatic compare_result();
		decode_result_t want;
		decode_result_t got;
		got = '{symbol: dout.symbol, decode_error: dout.decode_error, last: dout.last,
			done_res: dout.done_res};
		if (expected_symbols.size() == 0) begin
			n_fail++;
			if (n_reports < REPORT_LIMIT) begin
				n_reports++;
				$display("[%0t] result with nothing pending: symbol %02h err %b last %b done %b",
					$realtime, got.symbol, got.decode_error, got.last, got.done_res);
			end
			return;
		end
		want = expected_symbols.pop_front();
		n_checked++;
		if (want.symbol !== got.symbol || want.decode_error !== got.decode_error ||
				want.last !== got.last || want.done_res !== got.done_res) begin
			n_fail++;
			if (n_reports < REPORT_LIMIT) begin
				n_reports++;
				$display("[%0t] result %0d mismatch: expected symbol %02h err %b last %b done %b",
					$realtime, n_checked, want.symbol, want.decode_error, want.last,
					want.done_res);
				$display("    got symbol %02h err %b last %b done %b",
					got.symbol, got.decode_error, got.last, got.done_res);
			end
		end
	endtask

	// Transfers on all three channels, in the order the block sees them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				entry_on[i] = 1'b0;
			end
			rearm_candidates();
			decoded = '0;
			target_count = '0;
			expected_symbols.delete();
			n_fail = 0;
			n_checked = 0;
			n_reports = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
			decoded_total <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				target_count = cfg.symbol_count;
			end
			if (din.valid && din.ready) begin
				if (op_t'(din.op) == OP_LOAD) begin
					store_entry(din.entry_index, din.entry_symbol, din.entry_code,
						din.entry_length);
				end else begin
					decode_byte(din.data_byte);
				end
			end
			if (dout.valid && dout.ready) begin
				compare_result();
			end
			fail_count <= n_fail;
			pending <= expected_symbols.size();
			checked <= n_checked;
			decoded_total <= decoded;
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the Huffman table decoder testbench: clock, reset, stimulus on the
// input and symbol-count channels, random result back-pressure and the verdict.
// Depends on htd_pkg, htd_if, huffman_table_decoder_unit and htd_result_checker.
module testbench;
	import htd_pkg::*;

	localparam int RANDOM_ITEMS = 330;
	localparam int MAX_GAP      = 16;
	localparam int DRAIN_CYCLES = 40;
	localparam int RUN_LIMIT    = 2000000;

	logic clk = 1'b0;
	logic arst_n;

	htd_in_if  din();
	htd_out_if dout();
	htd_cfg_if cfg();

	huffman_table_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	int          fail_count;
	int          pending;
	int          checked;
	logic [31:0] decoded_total;

	htd_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.din           (din),
		.dout          (dout),
		.cfg           (cfg),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.decoded_total (decoded_total)
	);

	// Clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run bookkeeping
	bit          in_calm;
	bit          out_calm;
	logic [31:0] count_now;
	int          live_items;
	int          load_items;
	int          byte_items;
	int          ignored_bytes;
	int          count_writes;

	// Current code set: code bits, lengths, symbols and table positions
	logic [31:0] set_code[$];
	int          set_len[$];
	logic [7:0]  set_sym[$];
	logic [7:0]  set_idx[$];
	bit          placed[256];

	// One transfer on the input channel, after a random gap
	task automatic push_item(input op_t op, input logic [7:0] idx, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len, input logic [7:0] data);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
		if ($urandom_range(0, 15) == 0) begin
			in_calm = !in_calm;
		end
		if (gap > 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din.valid        <= 1'b1;
		din.op           <= op;
		din.entry_index  <= idx;
		din.entry_symbol <= sym;
		din.entry_code   <= code;
		din.entry_length <= len;
		din.data_byte    <= data;
		do @(posedge clk); while (!din.ready);
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [7:0] sym,
			input logic [31:0] code, input logic [5:0] len);
		push_item(OP_LOAD, idx, sym, code, len, 8'($urandom()));
		live_items++;
		load_items++;
	endtask

	task automatic feed_byte(input logic [7:0] data);
		// bytes past the symbol count are dropped by the block
		if (decoded_total < count_now) begin
			live_items++;
		end else begin
			ignored_bytes++;
		end
		byte_items++;
		push_item(OP_DATA, 8'($urandom()), 8'($urandom()), $urandom(), 6'($urandom()), data);
	endtask

	task automatic write_count(input logic [31:0] value);
		cfg.valid        <= 1'b1;
		cfg.symbol_count <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		count_now = value;
		count_writes++;
	endtask

	// Wait until every predicted result is out and the block has gone quiet
	task automatic settle();
		din.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Prefix-free code set by splitting leaves of a binary tree
	task automatic build_code_set(input int leaves, input bit chain);
		int pick;
		int tries;
		int l;
		logic [31:0] c;
		set_code.delete();
		set_len.delete();
		set_code.insert(0, 32'd0);
		set_len.insert(0, 0);
		tries = 0;
		while (set_code.size() < leaves && tries < 1000) begin
			tries++;
			pick = chain ? set_code.size() - 1 : $urandom_range(0, set_code.size() - 1);
			if (set_len[pick] >= MAX_CODE_LEN_DEF) begin
				continue;
			end
			c = set_code[pick];
			l = set_len[pick];
			set_code.delete(pick);
			set_len.delete(pick);
			set_code.insert(set_code.size(), c);
			set_len.insert(set_len.size(), l + 1);
			set_code.insert(set_code.size(), c | (32'd1 << l));
			set_len.insert(set_len.size(), l + 1);
		end
	endtask

	// Load a fresh code set at random positions; stale positions get dead lengths
	task automatic load_code_table();
		bit taken[256];
		bit chain;
		int leaves;
		int k;
		logic [7:0] idx;
		logic [31:0] mask;
		chain = ($urandom_range(0, 5) == 0);
		leaves = chain ? $urandom_range(24, 33) : $urandom_range(2, 12);
		build_code_set(leaves, chain);
		// sometimes leave a hole in the code space so errors occur
		if (set_code.size() > 2 && $urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, set_code.size() - 1);
			set_code.delete(k);
			set_len.delete(k);
		end
		set_sym.delete();
		set_idx.delete();
		foreach (set_code[k]) begin
			do idx = 8'($urandom_range(0, 255)); while (taken[idx]);
			taken[idx] = 1'b1;
			// bits past the length are don't-care, fill them at random
			mask = (set_len[k] == 32) ? '1 : ((32'd1 << set_len[k]) - 1);
			set_code[k] = set_code[k] | ($urandom() & ~mask);
			set_idx.insert(set_idx.size(), idx);
			set_sym.insert(set_sym.size(), 8'($urandom_range(0, 255)));
			load_entry(idx, set_sym[k], set_code[k], 6'(set_len[k]));
		end
		for (int i = 0; i < 256; i++) begin
			if (placed[i] && !taken[i]) begin
				load_entry(8'(i), 8'($urandom()), $urandom(),
					($urandom_range(0, 1) != 0) ? 6'd0 : 6'($urandom_range(33, 63)));
			end
		end
		placed = taken;
	endtask

	// Encode random symbols of the current set, with noise bits, bytes and loads
	task automatic send_stream(input int nbytes);
		bit bits[$];
		int k;
		logic [7:0] b;
		logic [7:0] idx;
		while (bits.size() < 8 * nbytes) begin
			k = $urandom_range(0, set_code.size() - 1);
			for (int j = 0; j < set_len[k]; j++) begin
				bits.insert(bits.size(), set_code[k][j]);
			end
			if ($urandom_range(0, 19) == 0) begin
				bits.insert(bits.size(), 1'($urandom_range(0, 1)));
			end
		end
		while (bits.size() > 0) begin
			for (int j = 0; j < 8; j++) begin
				b[j] = (bits.size() > 0) ? bits.pop_front() : 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 9) == 0) begin
				b = 8'($urandom_range(0, 255));
			end
			feed_byte(b);
			if ($urandom_range(0, 24) == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					idx = 8'($urandom_range(0, 255));
					placed[idx] = 1'b1;
					load_entry(idx, 8'($urandom()), $urandom(), 6'($urandom_range(0, 63)));
				end else begin
					// same entry again, likely in the middle of a code
					k = $urandom_range(0, set_idx.size() - 1);
					load_entry(set_idx[k], set_sym[k], set_code[k], 6'(set_len[k]));
				end
			end
		end
	endtask

	// Directed items: extremes, empty table, priority, loads mid-code, count stop
	task automatic run_directed();
		feed_byte(8'hA5);
		settle();
		write_count(32'hFFFF_FFFF);
		feed_byte(8'h00);
		feed_byte(8'hFF);
		load_entry(8'd0,   8'h00, 32'h0000_0000, 6'd1);
		load_entry(8'd1,   8'h80, 32'h0000_0001, 6'd2);
		load_entry(8'd255, 8'hFF, 32'hFFFF_FFFF, 6'd32);
		load_entry(8'd128, 8'h55, 32'hAAAA_AAAA, 6'd0);
		load_entry(8'd127, 8'hAA, 32'h5555_5555, 6'd63);
		load_entry(8'd64,  8'h33, 32'h0000_0003, 6'd3);
		feed_byte(8'h00);
		feed_byte(8'h55);
		repeat (4) feed_byte(8'hFF);
		feed_byte(8'h03);
		feed_byte(8'h87);
		load_entry(8'd2, 8'h22, 32'h0000_0001, 6'd1);
		feed_byte(8'h00);
		feed_byte(8'h01);
		settle();
		write_count(decoded_total + 2);
		feed_byte(8'h00);
		feed_byte(8'h00);
		foreach (placed[i]) begin
			placed[i] = (i == 0 || i == 1 || i == 2 || i == 64 || i == 127 || i == 128 ||
				i == 255);
		end
	endtask

	// Result side back-pressure
	initial begin
		int stall;
		dout.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 15) == 0) begin
				out_calm = !out_calm;
			end
			if (stall > 0) begin
				dout.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout.ready <= 1'b1;
			do @(posedge clk); while (!dout.valid);
		end
	end

	// Stimulus and verdict
	initial begin
		int start_items;
		int phase;
		arst_n           <= 1'b0;
		din.valid        <= 1'b0;
		din.op           <= OP_LOAD;
		din.entry_index  <= '0;
		din.entry_symbol <= '0;
		din.entry_code   <= '0;
		din.entry_length <= '0;
		din.data_byte    <= '0;
		cfg.valid        <= 1'b0;
		cfg.symbol_count <= '0;
		count_now = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Random phases, each with its own symbol count and code set
		start_items = live_items;
		phase = 0;
		while (live_items - start_items < RANDOM_ITEMS) begin
			settle();
			case (phase % 4)
				0: write_count(32'hFFFF_FFFF);
				1: write_count(decoded_total + $urandom_range(1, 40));
				2: write_count(32'h0000_0000);
				default: write_count(decoded_total + $urandom_range(41, 300));
			endcase
			load_code_table();
			send_stream((phase % 4 == 2) ? 2 : $urandom_range(8, 24));
			phase++;
		end

		settle();
		$display("covered %0d table loads, %0d data bytes (%0d past the count), %0d count writes",
			load_items, byte_items, ignored_bytes, count_writes);
		$display("compared %0d results, %0d symbols decoded, %0d mismatches",
			checked, decoded_total, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#RUN_LIMIT;
		$display("run stopped after %0d time units with %0d results outstanding",
			RUN_LIMIT, pending);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== huffman_table_decoder_unit.f =====
hdl/htd_pkg.sv
hdl/htd_if.sv
hdl/htd_ram.sv
hdl/htd_ctrl.sv
hdl/htd_datapath.sv
hdl/huffman_table_decoder_unit.sv
verif/htd_result_checker.sv
verif/testbench.sv
